// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the PT100 converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, clocked on clk and disabled while arst_n is low.
`define PT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that a condition never holds.
`define PT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/pt100_pkg.sv -----
// Package with the constants, the resistance table and the control types of the PT100 converter.
`default_nettype none

package pt100_pkg;

	localparam int RES_W             = 16;
	localparam int STATUS_W          = 2;
	localparam int TEMP_W            = 19;
	localparam int TABLE_ENTRIES     = 96;
	localparam int ADDR_W            = $clog2(TABLE_ENTRIES);
	localparam int IDX_W             = $clog2(TABLE_ENTRIES + 1);
	localparam int FRACTION_BITS_DEF = 8;
	localparam int SPAN_W            = 9;
	localparam int NUM_W             = 12;
	localparam int DEG_W             = 12;
	localparam int START_C           = -100;
	localparam int STEP_C            = 10;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OPEN  = 2'd2;

	localparam logic [RES_W-1:0] RTD_ROM [TABLE_ENTRIES] = '{
		16'd6026,  16'd6430,  16'd6833,  16'd7233,  16'd7633,
		16'd8031,  16'd8427,  16'd8822,  16'd9216,  16'd9609,
		16'd10000, 16'd10390, 16'd10779, 16'd11167, 16'd11554,
		16'd11940, 16'd12324, 16'd12708, 16'd13090, 16'd13471,
		16'd13851, 16'd14229, 16'd14607, 16'd14983, 16'd15358,
		16'd15733, 16'd16105, 16'd16477, 16'd16848, 16'd17217,
		16'd17586, 16'd17953, 16'd18319, 16'd18684, 16'd19047,
		16'd19410, 16'd19771, 16'd20131, 16'd20490, 16'd20848,
		16'd21205, 16'd21561, 16'd21915, 16'd22268, 16'd22621,
		16'd22972, 16'd23321, 16'd23670, 16'd24018, 16'd24364,
		16'd24709, 16'd25053, 16'd25396, 16'd25738, 16'd26078,
		16'd26418, 16'd26756, 16'd27093, 16'd27429, 16'd27764,
		16'd28098, 16'd28430, 16'd28762, 16'd29092, 16'd29421,
		16'd29749, 16'd30075, 16'd30401, 16'd30725, 16'd31048,
		16'd31371, 16'd31692, 16'd32012, 16'd32330, 16'd32648,
		16'd32964, 16'd33279, 16'd33593, 16'd33906, 16'd34218,
		16'd34528, 16'd34838, 16'd35146, 16'd35453, 16'd35759,
		16'd36064, 16'd36367, 16'd36670, 16'd36971, 16'd37271,
		16'd37570, 16'd37868, 16'd38165, 16'd38460, 16'd38755,
		16'd39048
	};

	// Addresses past the table read as zero; the search never issues them.
	function automatic logic [RES_W-1:0] rom_value(input logic [ADDR_W-1:0] addr);
		logic [RES_W-1:0] val;
		val = '0;
		if (int'(addr) < TABLE_ENTRIES) begin
			val = RTD_ROM[addr];
		end
		return val;
	endfunction

	typedef struct packed {
		logic start;
		logic search_step;
		logic fetch_hi;
		logic fetch_lo;
		logic div_step;
		logic load_out;
	} pt100_cmd_t;

	typedef struct packed {
		logic search_done;
		logic seg_err;
		logic div_last;
	} pt100_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pt100_in_if.sv -----
// Handshake interface that carries one resistance word.
`default_nettype none

interface pt100_in_if;
	logic                        valid;
	logic                        ready;
	logic [pt100_pkg::RES_W-1:0] resistance_centiohm;

	modport source (output valid, output resistance_centiohm, input ready);
	modport sink (input valid, input resistance_centiohm, output ready);
endinterface

`default_nettype wire

// ----- rtl/pt100_out_if.sv -----
// Handshake interface that carries one status and temperature word.
`default_nettype none

interface pt100_out_if;
	logic                                valid;
	logic                                ready;
	logic [pt100_pkg::STATUS_W-1:0]      status;
	logic signed [pt100_pkg::TEMP_W-1:0] temperature_q8;

	modport source (output valid, output status, output temperature_q8, input ready);
	modport sink (input valid, input status, input temperature_q8, output ready);
endinterface

`default_nettype wire

// ----- rtl/pt100_resistance_to_temperature.sv -----
// Top level of the PT100 resistance to temperature converter.
`default_nettype none

// Channel  Direction  Payload
// req      in         resistance_centiohm[15:0], unsigned, 0.01 ohm
// rsp      out        status[1:0], temperature_q8[18:0] signed, 2^-FRACTION_BITS C
//
// An accepted in-range word passes through six or seven binary search steps
// over the table, two table reads and one restoring divide step per dividend
// bit before it is loaded into the output register. Short and open readings
// skip the table reads and the divide.
// Reset returns the controller to idle and empties the output register.
// A new word is taken while a finished word waits on rsp; the block stalls
// only when the next result is ready and the output register is still full.

`include "assert_macros.svh"

module pt100_resistance_to_temperature #(
	parameter int FRACTION_BITS = pt100_pkg::FRACTION_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	pt100_in_if.sink    req,
	pt100_out_if.source rsp
);
	import pt100_pkg::*;

	// Command and status buses between the controller and the datapath.
	pt100_cmd_t cmd;
	pt100_sts_t sts;

	// The controller owns the handshakes; the datapath owns every payload bit.
	pt100_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath captures the reading on start and writes the output word on load.
	pt100_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk            (clk),
		.in_res         (req.resistance_centiohm),
		.cmd            (cmd),
		.sts            (sts),
		.status         (rsp.status),
		.temperature_q8 (rsp.temperature_q8)
	);

	// An accepted word always starts with a search step, since the range is never empty.
	`PT_ASSERT(a_start_search, (req.valid && req.ready) |=> cmd.search_step, "no search after accept")
	// At most one datapath operation is commanded in any cycle.
	`PT_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
	// A loaded result is presented on the next cycle.
	`PT_ASSERT(a_load_valid, cmd.load_out |=> rsp.valid, "loaded result not presented")
	// An error status always comes with a zero temperature.
	`PT_ASSERT(a_err_zero, (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.temperature_q8 == '0), "error status with nonzero temperature")

endmodule

`default_nettype wire

// ----- rtl/pt100_ctrl.sv -----
// Controller state machine that sequences search, table fetch, divide and output load.
`default_nettype none

module pt100_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire pt100_pkg::pt100_sts_t sts,
	output pt100_pkg::pt100_cmd_t      cmd
);
	import pt100_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEARCH   = 3'd1;
	localparam logic [2:0] ST_FETCH_HI = 3'd2;
	localparam logic [2:0] ST_FETCH_LO = 3'd3;
	localparam logic [2:0] ST_DIVIDE   = 3'd4;
	localparam logic [2:0] ST_FINISH   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!sts.search_done) begin
					cmd.search_step = 1'b1;
				end else if (sts.seg_err) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_FETCH_HI;
				end
			end
			ST_FETCH_HI: begin
				cmd.fetch_hi = 1'b1;
				state_d      = ST_FETCH_LO;
			end
			ST_FETCH_LO: begin
				cmd.fetch_lo = 1'b1;
				state_d      = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The output register takes the result once it is empty or being drained.
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pt100_datapath.sv -----
// Datapath with the table search registers, the serial divider and the output word register.
`default_nettype none

module pt100_datapath #(
	parameter int FRACTION_BITS = pt100_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic [pt100_pkg::RES_W-1:0]         in_res,
	input  wire pt100_pkg::pt100_cmd_t               cmd,
	output pt100_pkg::pt100_sts_t                    sts,
	output logic [pt100_pkg::STATUS_W-1:0]           status,
	output logic signed [pt100_pkg::TEMP_W-1:0]      temperature_q8
);
	import pt100_pkg::*;

	localparam int DVD_W = NUM_W + FRACTION_BITS;
	localparam int QUO_W = FRACTION_BITS + 4;
	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int SUM_W = (FRACTION_BITS + DEG_W > TEMP_W) ? FRACTION_BITS + DEG_W : TEMP_W + 1;
	localparam logic signed [SUM_W-1:0] TMAX = SUM_W'((1 << (TEMP_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] TMIN = SUM_W'(-(1 << (TEMP_W - 1)));

	logic [RES_W-1:0]  res_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  km1;
	logic [ADDR_W-1:0] rom_addr;
	logic [RES_W-1:0]  rom_data;
	logic [RES_W-1:0]  upper_q;
	logic [SPAN_W-1:0] span_q;
	logic [SPAN_W-1:0] rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SPAN_W-1:0] diff;
	logic [NUM_W-1:0]  num;
	logic [SPAN_W:0]   trial;
	logic              qbit;
	logic signed [DEG_W-1:0] deg;
	logic signed [SUM_W-1:0] sum;
	logic signed [TEMP_W-1:0] temp_sat;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign km1 = lo_q - IDX_W'(1);

	always_comb begin
		rom_addr = mid[ADDR_W-1:0];
		if (cmd.fetch_hi) begin
			rom_addr = lo_q[ADDR_W-1:0];
		end else if (cmd.fetch_lo) begin
			rom_addr = km1[ADDR_W-1:0];
		end
	end

	assign rom_data = rom_value(rom_addr);

	// The reading lies above the lower entry and at or below the upper one.
	assign diff = SPAN_W'(res_q - rom_data);
	assign num  = {diff, 3'b000} + {2'b00, diff, 1'b0};

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, span_q});

	assign deg = DEG_W'($signed({1'b0, km1}) * STEP_C + START_C);
	assign sum = ($signed(SUM_W'(deg)) <<< FRACTION_BITS)
		+ $signed({{(SUM_W - QUO_W){1'b0}}, quo_q});

	always_comb begin
		temp_sat = sum[TEMP_W-1:0];
		if (sum > TMAX) begin
			temp_sat = TMAX[TEMP_W-1:0];
		end else if (sum < TMIN) begin
			temp_sat = TMIN[TEMP_W-1:0];
		end
	end

	assign sts.search_done = (lo_q == hi_q);
	assign sts.seg_err     = (lo_q == '0) || (lo_q == IDX_W'(TABLE_ENTRIES));
	assign sts.div_last    = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q <= in_res;
			lo_q  <= '0;
			hi_q  <= IDX_W'(TABLE_ENTRIES);
		end
		if (cmd.search_step) begin
			if (res_q <= rom_data) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + IDX_W'(1);
			end
		end
		if (cmd.fetch_hi) begin
			upper_q <= rom_data;
		end
		if (cmd.fetch_lo) begin
			span_q <= SPAN_W'(upper_q - rom_data);
			dvd_q  <= {num, {FRACTION_BITS{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= CNT_W'(DVD_W);
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? SPAN_W'(trial - {1'b0, span_q}) : trial[SPAN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], qbit};
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.load_out) begin
			if (lo_q == '0) begin
				status         <= STATUS_SHORT;
				temperature_q8 <= '0;
			end else if (lo_q == IDX_W'(TABLE_ENTRIES)) begin
				status         <= STATUS_OPEN;
				temperature_q8 <= '0;
			end else begin
				status         <= STATUS_OK;
				temperature_q8 <= temp_sat;
			end
		end
	end

endmodule

`default_nettype wire
